### sv/sidq_pkg.sv
// Shared types and constants for the switch input debounce qualifier.
// Holds the channel words, debouncer codes, thresholds and register indexes.
// No dependencies.
package sidq_pkg;

   localparam int SWITCH_COUNT = 9;
   localparam int COUNT_WIDTH = 8;

   localparam logic [1:0] OP_SCAN = 2'd0;
   localparam logic [1:0] OP_QUAL_ENABLE = 2'd1;
   localparam logic [1:0] OP_QUAL_STARTNOW = 2'd2;

   localparam logic [1:0] REG_PRESSURE_MODE = 2'd0;
   localparam logic [1:0] REG_PRESSURE_LIMIT = 2'd1;
   localparam logic [1:0] REG_ACTIVE_WHEN_OPEN = 2'd2;

   localparam logic [2:0] ST_OPEN = 3'd0;
   localparam logic [2:0] ST_CLOSING_A = 3'd1;
   localparam logic [2:0] ST_CLOSING_B = 3'd2;
   localparam logic [2:0] ST_CLOSED = 3'd3;
   localparam logic [2:0] ST_OPENING_A = 3'd4;
   localparam logic [2:0] ST_OPENING_B = 3'd5;

   localparam int SW_ENABLE = 1;
   localparam int SW_STARTNOW = 8;

   localparam logic [11:0] ENABLE_HIGH = 12'hA00;
   localparam logic [15:0] START_HIGH = 16'h2400;
   localparam logic [15:0] CTRL_LOW = 16'h02F0;
   localparam logic [15:0] REGEN_HIGH = 16'h3800;
   localparam logic [15:0] STARTNOW_HIGH = 16'h3000;

   typedef struct packed {
      logic [1:0]  opcode;
      logic        filter_pin;
      logic [11:0] enable_raw;
      logic        power_pin;
      logic [15:0] start_ctrl_avg;
      logic [15:0] regen_ctrl_avg;
      logic [15:0] startnow_avg;
      logic [15:0] pressure_now;
   } req_word_type;

   typedef struct packed {
      logic [SWITCH_COUNT-1:0] closed_mask;
      logic                    auto_enable;
      logic                    start_now;
   } rsp_word_type;

   typedef struct packed {
      logic [2:0]              enable_state;
      logic [2:0]              sn_switch_state;
      logic [SWITCH_COUNT-1:0] closed_mask_next;
   } sw_status_type;

   typedef struct packed {
      logic flag;
      logic flag_next;
   } qual_status_type;

endpackage

### sv/sidq_debounce.sv
// Level decode and six-state debouncer bank for all nine switches.
// Depends on sidq_pkg.
module sidq_debounce (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  step,
   input  sidq_pkg::req_word_type word,
   output sidq_pkg::sw_status_type status
);

   logic [2:0] state_ff [sidq_pkg::SWITCH_COUNT];
   logic [2:0] state_in [sidq_pkg::SWITCH_COUNT];
   logic [sidq_pkg::SWITCH_COUNT-1:0] level;

   function automatic logic [2:0] next_state(input logic [2:0] cur, input logic lv);
      logic [2:0] nxt;
      case (cur)
         sidq_pkg::ST_OPEN:      nxt = lv ? sidq_pkg::ST_CLOSING_A : sidq_pkg::ST_OPEN;
         sidq_pkg::ST_CLOSING_A: nxt = lv ? sidq_pkg::ST_CLOSING_B : sidq_pkg::ST_OPEN;
         sidq_pkg::ST_CLOSING_B: nxt = lv ? sidq_pkg::ST_CLOSED : sidq_pkg::ST_OPEN;
         sidq_pkg::ST_CLOSED:    nxt = lv ? sidq_pkg::ST_CLOSED : sidq_pkg::ST_OPENING_A;
         sidq_pkg::ST_OPENING_A: nxt = lv ? sidq_pkg::ST_CLOSED : sidq_pkg::ST_OPENING_B;
         sidq_pkg::ST_OPENING_B: nxt = lv ? sidq_pkg::ST_CLOSED : sidq_pkg::ST_OPEN;
         default:                nxt = sidq_pkg::ST_OPEN;
      endcase
      return nxt;
   endfunction

   always_comb begin
      level[0] = ~word.filter_pin;
      level[1] = word.enable_raw > sidq_pkg::ENABLE_HIGH;
      level[2] = word.power_pin;
      level[3] = word.start_ctrl_avg > sidq_pkg::START_HIGH;
      level[4] = word.start_ctrl_avg < sidq_pkg::CTRL_LOW;
      level[5] = 1'b0;
      level[6] = word.regen_ctrl_avg < sidq_pkg::CTRL_LOW;
      level[7] = word.regen_ctrl_avg > sidq_pkg::REGEN_HIGH;
      level[8] = word.startnow_avg > sidq_pkg::STARTNOW_HIGH;
   end

   always_comb begin
      for (int i = 0; i < sidq_pkg::SWITCH_COUNT; i++) begin
         state_in[i] = (step && word.opcode == sidq_pkg::OP_SCAN) ?
                       next_state(state_ff[i], level[i]) : state_ff[i];
         status.closed_mask_next[i] = state_in[i] == sidq_pkg::ST_CLOSED;
      end
      status.enable_state = state_ff[sidq_pkg::SW_ENABLE];
      status.sn_switch_state = state_ff[sidq_pkg::SW_STARTNOW];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < sidq_pkg::SWITCH_COUNT; i++) begin
            state_ff[i] <= sidq_pkg::ST_OPEN;
         end
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

### sv/sidq_qualifier.sv
// Saturating counter qualifier that toggles a flag after enough agreeing samples.
// Depends on sidq_pkg.
module sidq_qualifier #(
   parameter int QUALIFY_COUNT = 3
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     step,
   input  logic                     agree,
   output sidq_pkg::qual_status_type status
);

   localparam logic [sidq_pkg::COUNT_WIDTH-1:0] COUNT_MAX = '1;
   localparam logic [sidq_pkg::COUNT_WIDTH-1:0] LIMIT = sidq_pkg::COUNT_WIDTH'(QUALIFY_COUNT);

   logic [sidq_pkg::COUNT_WIDTH-1:0] count_ff, count_in;
   logic flag_ff, flag_in;

   always_comb begin
      count_in = count_ff;
      flag_in = flag_ff;
      if (step) begin
         if (!agree) begin
            count_in = '0;
         end else if (count_ff != COUNT_MAX) begin
            count_in = count_ff + 1'b1;
         end
         if (count_in >= LIMIT) begin
            flag_in = ~flag_ff;
         end
      end
   end

   assign status.flag = flag_ff;
   assign status.flag_next = flag_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         flag_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         flag_ff <= flag_in;
      end
   end

endmodule

### sv/switch_input_debounce_qualifier_core.sv
// Top level: input word register, debouncer bank, two qualifiers, result register.
// Depends on sidq_pkg, sidq_debounce and sidq_qualifier.
// A word moves on to the result register when that is empty or rsp_stall is low.
// Throughput: one word per cycle unless rsp_stall holds a full result register;
// every tick is one compare-and-count pass between the input and result registers.
// Reset (synchronous): switches open, counters and flags clear, config registers zero.
module switch_input_debounce_qualifier_core #(
   parameter int QUALIFY_COUNT = 3
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  sidq_pkg::req_word_type req_word,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output sidq_pkg::rsp_word_type rsp_word,
   input  logic                   psel,
   input  logic                   penable,
   input  logic                   pwrite,
   input  logic [3:0]             paddr,
   input  logic [31:0]            pwdata,
   output logic [31:0]            prdata,
   output logic                   pready
);

   logic                   in_vld_ff;
   sidq_pkg::req_word_type in_word_ff;
   logic                   out_vld_ff;
   sidq_pkg::rsp_word_type out_word_ff;
   logic                   move;

   logic        pressure_mode_ff;
   logic [15:0] pressure_limit_ff;
   logic        active_when_open_ff;
   logic        csr_write;
   logic [1:0]  csr_index;

   sidq_pkg::sw_status_type   sw_status;
   sidq_pkg::qual_status_type en_status;
   sidq_pkg::qual_status_type sn_status;
   logic en_agree, sn_agree, pressure_low, sn_active;
   logic en_step, sn_step;

   assign move = in_vld_ff & (~out_vld_ff | ~rsp_stall);
   assign req_stall = in_vld_ff & ~move;
   assign rsp_valid = out_vld_ff;
   assign rsp_word = out_word_ff;

   // configuration port
   assign pready = 1'b1;
   assign csr_index = paddr[3:2];
   assign csr_write = psel & penable & pwrite;

   always_comb begin
      prdata = '0;
      case (csr_index)
         sidq_pkg::REG_PRESSURE_MODE:    prdata = {31'd0, pressure_mode_ff};
         sidq_pkg::REG_PRESSURE_LIMIT:   prdata = {16'd0, pressure_limit_ff};
         sidq_pkg::REG_ACTIVE_WHEN_OPEN: prdata = {31'd0, active_when_open_ff};
         default:                        prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pressure_mode_ff <= 1'b0;
         pressure_limit_ff <= '0;
         active_when_open_ff <= 1'b0;
      end else if (csr_write) begin
         case (csr_index)
            sidq_pkg::REG_PRESSURE_MODE:    pressure_mode_ff <= pwdata[0];
            sidq_pkg::REG_PRESSURE_LIMIT:   pressure_limit_ff <= pwdata[15:0];
            sidq_pkg::REG_ACTIVE_WHEN_OPEN: active_when_open_ff <= pwdata[0];
            default: ;
         endcase
      end
   end

   // tick datapath
   sidq_debounce u_debounce (
      .clock  (clock),
      .reset  (reset),
      .step   (move),
      .word   (in_word_ff),
      .status (sw_status)
   );

   assign en_step = move && in_word_ff.opcode == sidq_pkg::OP_QUAL_ENABLE;
   assign sn_step = move && in_word_ff.opcode == sidq_pkg::OP_QUAL_STARTNOW;

   assign en_agree = sw_status.enable_state ==
                     (en_status.flag ? sidq_pkg::ST_OPEN : sidq_pkg::ST_CLOSED);
   assign pressure_low = in_word_ff.pressure_now < pressure_limit_ff;
   assign sn_active = sw_status.sn_switch_state ==
                      (active_when_open_ff ? sidq_pkg::ST_OPEN : sidq_pkg::ST_CLOSED);
   assign sn_agree = (pressure_mode_ff ? pressure_low : sn_active) ^ sn_status.flag;

   sidq_qualifier #(.QUALIFY_COUNT(QUALIFY_COUNT)) u_qual_enable (
      .clock  (clock),
      .reset  (reset),
      .step   (en_step),
      .agree  (en_agree),
      .status (en_status)
   );

   sidq_qualifier #(.QUALIFY_COUNT(QUALIFY_COUNT)) u_qual_startnow (
      .clock  (clock),
      .reset  (reset),
      .step   (sn_step),
      .agree  (sn_agree),
      .status (sn_status)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
         out_vld_ff <= 1'b0;
      end else begin
         if (req_valid && !req_stall) begin
            in_vld_ff <= 1'b1;
         end else if (move) begin
            in_vld_ff <= 1'b0;
         end
         if (move) begin
            out_vld_ff <= 1'b1;
         end else if (!rsp_stall) begin
            out_vld_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && !req_stall) begin
         in_word_ff <= req_word;
      end
      if (move) begin
         out_word_ff.closed_mask <= sw_status.closed_mask_next;
         out_word_ff.auto_enable <= en_status.flag_next;
         out_word_ff.start_now <= sn_status.flag_next;
      end
   end

endmodule

### sv/sidq_checker.sv
// Port-level checks for the switch input debounce qualifier core, with its bind.
// Depends on sidq_pkg and switch_input_debounce_qualifier_core.
module sidq_checker (
   input logic                   clock,
   input logic                   reset,
   input logic                   req_valid,
   input logic                   req_stall,
   input logic                   rsp_valid,
   input logic                   rsp_stall,
   input sidq_pkg::rsp_word_type rsp_word
);

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_word))
      else $error("result word changed while stalled");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("pipeline not empty after reset");

   a_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid && rsp_stall)
      else $error("input stalled without result backpressure");

   a_latency: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) ##1 !rsp_stall |=> rsp_valid)
      else $error("accepted word did not reach the result register");

endmodule

bind switch_input_debounce_qualifier_core sidq_checker u_sidq_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_word  (rsp_word)
);

### sim/switch_input_debounce_qualifier_core_tb.sv
// Self-checking testbench for switch_input_debounce_qualifier_core: a directed table, then
// random scan, qualify and noise words under several register settings, all scored in order.
// Depends on sidq_pkg and the core RTL.
`timescale 1ns / 1ps

module switch_input_debounce_qualifier_core_tb;
   import sidq_pkg::*;

   localparam int QUALIFY_COUNT = 3;
   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam int PHASE_COUNT = 6;
   localparam int PHASE_WORDS = 210;
   localparam int SATURATE_RUN = 270;

   typedef struct {
      req_word_type word;
      logic         fixed;
      rsp_word_type result;
   } stim_row_type;

   logic         clock;
   logic         reset = 1'b1;
   logic         req_valid = 1'b0;
   logic         req_stall;
   req_word_type req_word = '0;
   logic         rsp_valid;
   logic         rsp_stall = 1'b0;
   rsp_word_type rsp_word;
   logic         psel = 1'b0;
   logic         penable = 1'b0;
   logic         pwrite = 1'b0;
   logic [3:0]   paddr = '0;
   logic [31:0]  pwdata = '0;
   logic [31:0]  prdata;
   logic         pready;

   logic [2:0]   sw_state [SWITCH_COUNT];
   logic [7:0]   en_count, sn_count;
   logic         en_flag, sn_flag;
   logic         cfg_pressure_mode, cfg_active_open;
   logic [15:0]  cfg_pressure_limit;

   rsp_word_type expected_words [$];
   rsp_word_type want_word;
   stim_row_type directed_rows [$];
   logic         failed = 1'b0;
   logic         quiet = 1'b0;
   int           stall_left = 0;

   switch_input_debounce_qualifier_core #(.QUALIFY_COUNT(QUALIFY_COUNT)) dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_word(req_word),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_word(rsp_word),
      .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
      .pwdata(pwdata), .prdata(prdata), .pready(pready)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      #10_000_000;
      $display("status: fail");
      $finish;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (quiet || r < 55) return 0;
      if (r < 88) return $urandom_range(1, 3);
      return $urandom_range(6, 24);
   endfunction

   function automatic logic [2:0] debounce_next(logic [2:0] cur, logic lv);
      case (cur)
         ST_OPEN:      return lv ? ST_CLOSING_A : ST_OPEN;
         ST_CLOSING_A: return lv ? ST_CLOSING_B : ST_OPEN;
         ST_CLOSING_B: return lv ? ST_CLOSED : ST_OPEN;
         ST_CLOSED:    return lv ? ST_CLOSED : ST_OPENING_A;
         ST_OPENING_A: return lv ? ST_CLOSED : ST_OPENING_B;
         ST_OPENING_B: return lv ? ST_CLOSED : ST_OPEN;
         default:      return ST_OPEN;
      endcase
   endfunction

   // returns {flag, count}
   function automatic logic [8:0] qual_next(logic [7:0] cnt, logic flg, logic agree);
      logic [7:0] c;
      logic f;
      c = agree ? ((cnt == 8'hFF) ? cnt : cnt + 8'd1) : 8'd0;
      f = (c >= QUALIFY_COUNT) ? ~flg : flg;
      return {f, c};
   endfunction

   task automatic predict_tick(input req_word_type w, output rsp_word_type r);
      logic [8:0] lv;
      logic agree, low, is_act;
      case (w.opcode)
         OP_SCAN: begin
            lv[0] = ~w.filter_pin;
            lv[1] = w.enable_raw > ENABLE_HIGH;
            lv[2] = w.power_pin;
            lv[3] = w.start_ctrl_avg > START_HIGH;
            lv[4] = w.start_ctrl_avg < CTRL_LOW;
            lv[5] = 1'b0;
            lv[6] = w.regen_ctrl_avg < CTRL_LOW;
            lv[7] = w.regen_ctrl_avg > REGEN_HIGH;
            lv[8] = w.startnow_avg > STARTNOW_HIGH;
            for (int i = 0; i < SWITCH_COUNT; i++)
               sw_state[i] = debounce_next(sw_state[i], lv[i]);
         end
         OP_QUAL_ENABLE: begin
            agree = sw_state[SW_ENABLE] == (en_flag ? ST_OPEN : ST_CLOSED);
            {en_flag, en_count} = qual_next(en_count, en_flag, agree);
         end
         OP_QUAL_STARTNOW: begin
            if (cfg_pressure_mode) begin
               low = w.pressure_now < cfg_pressure_limit;
               agree = sn_flag ? ~low : low;
            end else begin
               is_act = sw_state[SW_STARTNOW] == (cfg_active_open ? ST_OPEN : ST_CLOSED);
               agree = sn_flag ? ~is_act : is_act;
            end
            {sn_flag, sn_count} = qual_next(sn_count, sn_flag, agree);
         end
         default: ;
      endcase
      for (int i = 0; i < SWITCH_COUNT; i++)
         r.closed_mask[i] = sw_state[i] == ST_CLOSED;
      r.auto_enable = en_flag;
      r.start_now = sn_flag;
   endtask

   task automatic send_word(input req_word_type w, input logic fixed = 1'b0,
                            input rsp_word_type fixed_result = '0);
      rsp_word_type r;
      int gap;
      req_valid <= 1'b1;
      req_word <= w;
      do @(posedge clock); while (req_stall);
      predict_tick(w, r);
      expected_words.push_back(fixed ? fixed_result : r);
      gap = pick_gap();
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic csr_write(input logic [1:0] idx, input logic [31:0] value);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= 1'b1;
      paddr <= {idx, 2'b00};
      pwdata <= value;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      psel <= 1'b0;
      penable <= 1'b0;
      pwrite <= 1'b0;
      case (idx)
         REG_PRESSURE_MODE:    cfg_pressure_mode = value[0];
         REG_PRESSURE_LIMIT:   cfg_pressure_limit = value[15:0];
         REG_ACTIVE_WHEN_OPEN: cfg_active_open = value[0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic drain();
      while (expected_words.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   function automatic req_word_type mk(logic [1:0] op, logic filt, logic [11:0] en, logic pw,
                                       logic [15:0] st, logic [15:0] rg, logic [15:0] sn,
                                       logic [15:0] pr);
      req_word_type w;
      w.opcode = op;
      w.filter_pin = filt;
      w.enable_raw = en;
      w.power_pin = pw;
      w.start_ctrl_avg = st;
      w.regen_ctrl_avg = rg;
      w.startnow_avg = sn;
      w.pressure_now = pr;
      return w;
   endfunction

   function automatic stim_row_type row(req_word_type w, logic fixed = 1'b0,
                                        rsp_word_type r = '0);
      stim_row_type s;
      s.word = w;
      s.fixed = fixed;
      s.result = r;
      return s;
   endfunction

   function automatic req_word_type noise_word();
      return mk(2'($urandom_range(0, 3)), 1'($urandom), 12'($urandom), 1'($urandom),
                16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
   endfunction

   function automatic req_word_type scan_word(logic [8:0] lv);
      req_word_type w;
      w = noise_word();
      w.opcode = OP_SCAN;
      w.filter_pin = ~lv[0];
      w.enable_raw = lv[1] ? 12'($urandom_range(ENABLE_HIGH + 1, 12'hFFF))
                           : 12'($urandom_range(0, ENABLE_HIGH));
      w.power_pin = lv[2];
      w.start_ctrl_avg = lv[3] ? 16'($urandom_range(START_HIGH + 1, 16'hFFFF))
                       : lv[4] ? 16'($urandom_range(0, CTRL_LOW - 1))
                       : 16'($urandom_range(CTRL_LOW, START_HIGH));
      w.regen_ctrl_avg = lv[7] ? 16'($urandom_range(REGEN_HIGH + 1, 16'hFFFF))
                       : lv[6] ? 16'($urandom_range(0, CTRL_LOW - 1))
                       : 16'($urandom_range(CTRL_LOW, REGEN_HIGH));
      w.startnow_avg = lv[8] ? 16'($urandom_range(STARTNOW_HIGH + 1, 16'hFFFF))
                             : 16'($urandom_range(0, STARTNOW_HIGH));
      return w;
   endfunction

   function automatic req_word_type qual_word(logic [1:0] op);
      req_word_type w;
      w = noise_word();
      w.opcode = op;
      if ($urandom_range(0, 1) && cfg_pressure_limit != 0)
         w.pressure_now = 16'($urandom_range(0, cfg_pressure_limit - 1));
      return w;
   endfunction

   always @(posedge clock) begin
      if (stall_left != 0) begin
         rsp_stall <= 1'b1;
         stall_left <= stall_left - 1;
      end else begin
         rsp_stall <= 1'b0;
         stall_left <= pick_gap();
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_words.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual %h", $time, rsp_word);
            failed <= 1'b1;
         end else begin
            want_word = expected_words.pop_front();
            if (rsp_word.closed_mask !== want_word.closed_mask) begin
               $display("%0t: closed_mask expected %h actual %h", $time,
                        want_word.closed_mask, rsp_word.closed_mask);
               failed <= 1'b1;
            end
            if (rsp_word.auto_enable !== want_word.auto_enable) begin
               $display("%0t: auto_enable expected %b actual %b", $time,
                        want_word.auto_enable, rsp_word.auto_enable);
               failed <= 1'b1;
            end
            if (rsp_word.start_now !== want_word.start_now) begin
               $display("%0t: start_now expected %b actual %b", $time,
                        want_word.start_now, rsp_word.start_now);
               failed <= 1'b1;
            end
         end
      end
   end

   initial begin
      req_word_type lows, highs, lo_ext, hi_ext, w;
      logic [8:0] lv;
      logic [15:0] lim;
      logic [15:0] limits [PHASE_COUNT];
      logic [PHASE_COUNT-1:0] modes, opens;
      int phase_words, r, n;

      for (int i = 0; i < SWITCH_COUNT; i++) sw_state[i] = ST_OPEN;
      en_count = '0;
      sn_count = '0;
      en_flag = 1'b0;
      sn_flag = 1'b0;
      cfg_pressure_mode = 1'b0;
      cfg_pressure_limit = '0;
      cfg_active_open = 1'b0;

      lows = mk(OP_SCAN, 1'b1, ENABLE_HIGH, 1'b0, CTRL_LOW, CTRL_LOW, STARTNOW_HIGH, 16'h0);
      highs = mk(OP_SCAN, 1'b0, ENABLE_HIGH + 12'd1, 1'b1, START_HIGH + 16'd1,
                 REGEN_HIGH + 16'd1, STARTNOW_HIGH + 16'd1, 16'h0);
      lo_ext = mk(OP_SCAN, 1'b1, 12'h0, 1'b0, 16'h0, 16'h0, 16'h0, 16'hFFFF);
      hi_ext = mk(OP_SCAN, 1'b0, 12'hFFF, 1'b1, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);

      directed_rows.push_back(row(lows, 1'b1, '0));
      directed_rows.push_back(row(mk(OP_UNUSED, 1'b1, 12'hFFF, 1'b1, 16'hFFFF, 16'hFFFF,
                                     16'hFFFF, 16'hFFFF), 1'b1, '0));
      directed_rows.push_back(row(highs, 1'b1, '0));
      directed_rows.push_back(row(highs, 1'b1, '0));
      directed_rows.push_back(row(highs, 1'b1, rsp_word_type'{9'h18F, 1'b0, 1'b0}));
      w = highs;
      w.opcode = OP_UNUSED;
      directed_rows.push_back(row(w, 1'b1, rsp_word_type'{9'h18F, 1'b0, 1'b0}));
      w.opcode = OP_QUAL_ENABLE;
      repeat (3) directed_rows.push_back(row(w));
      w.opcode = OP_QUAL_STARTNOW;
      repeat (3) directed_rows.push_back(row(w));
      directed_rows.push_back(row(lo_ext));
      directed_rows.push_back(row(highs));
      directed_rows.push_back(row(lo_ext));
      directed_rows.push_back(row(lo_ext));
      directed_rows.push_back(row(highs));
      repeat (3) directed_rows.push_back(row(lo_ext));
      w = lo_ext;
      w.opcode = OP_QUAL_ENABLE;
      directed_rows.push_back(row(w));
      w.opcode = OP_QUAL_STARTNOW;
      directed_rows.push_back(row(w));
      directed_rows.push_back(row(hi_ext));
      directed_rows.push_back(row(lows));

      modes = 6'b011010;
      opens = 6'b101100;
      limits[0] = 16'h0;
      limits[1] = 16'hFFFF;
      limits[2] = 16'h8000;
      limits[3] = 16'($urandom_range(1, 16'hFFFF));
      limits[4] = 16'h0;
      limits[5] = 16'($urandom);

      repeat (5) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         send_word(directed_rows[i].word, directed_rows[i].fixed, directed_rows[i].result);

      for (int ph = 0; ph < PHASE_COUNT; ph++) begin
         req_valid <= 1'b0;
         drain();
         csr_write(REG_PRESSURE_MODE, {31'b0, modes[ph]});
         csr_write(REG_PRESSURE_LIMIT, {16'b0, limits[ph]});
         csr_write(REG_ACTIVE_WHEN_OPEN, {31'b0, opens[ph]});
         quiet = (ph == 2);

         if (ph == 3) begin
            // alternate pressure so every sample agrees and the counter pins at its top
            lim = cfg_pressure_limit;
            for (int k = 0; k < SATURATE_RUN; k++) begin
               w = qual_word(OP_QUAL_STARTNOW);
               w.pressure_now = !sn_flag ? 16'($urandom_range(0, lim - 1))
                                         : 16'($urandom_range(lim, 16'hFFFF));
               send_word(w);
            end
            w.pressure_now = sn_flag ? 16'($urandom_range(0, lim - 1))
                                     : 16'($urandom_range(lim, 16'hFFFF));
            send_word(w);
         end

         phase_words = 0;
         while (phase_words < PHASE_WORDS) begin
            r = $urandom_range(0, 99);
            if (r < 60) begin
               lv = 9'($urandom);
               n = $urandom_range(3, 5);
               repeat (n) begin
                  if ($urandom_range(0, 5) == 0) lv[$urandom_range(0, 8)] ^= 1'b1;
                  send_word(scan_word(lv));
               end
               phase_words += n;
               n = $urandom_range(1, 4);
               repeat (n)
                  send_word(qual_word($urandom_range(0, 1) ? OP_QUAL_ENABLE
                                                           : OP_QUAL_STARTNOW));
               phase_words += n;
            end else if (r < 85) begin
               send_word(scan_word(9'($urandom)));
               phase_words++;
            end else begin
               send_word(noise_word());
               phase_words++;
            end
         end
      end

      req_valid <= 1'b0;
      while (expected_words.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (!failed && expected_words.size() == 0)
         $display("status: pass");
      else
         $display("status: fail");
      $finish;
   end

endmodule

### switch_input_debounce_qualifier_core.f
sv/sidq_pkg.sv
sv/sidq_debounce.sv
sv/sidq_qualifier.sv
sv/switch_input_debounce_qualifier_core.sv
sv/sidq_checker.sv
sim/switch_input_debounce_qualifier_core_tb.sv
